@@ hw/rtl/positional_list_engine_top_macros.svh @@
// Assertion macros used by the list engine's top-level RTL.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while reset is high.
`define PLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while reset is high.
`define PLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/plc_pkg.sv @@
package plc_pkg;

   // Default sizing of the list.
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_VALUE_BITS = 32;

   // Fixed field widths of the request and response.
   localparam int INDEX_BITS  = 16;
   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int RESULT_BITS = 32;
   localparam int COUNT_BITS  = 5;

   // Widest position the cell row ever sees (capacity of at most 256 entries).
   localparam int POS_MAX_BITS = 8;

   // Step counter of the remainder unit.
   localparam int STEP_BITS = $clog2(INDEX_BITS);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_GET    = 2'd2
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Operation broadcast to every cell of the row.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_LOAD,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [POS_MAX_BITS-1:0] pos;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_LOAD,
      S_SCAN,
      S_FINISH
   } state_type;

endpackage

@@ hw/rtl/positional_list_engine_top.sv @@
// Ordered list of up to CAPACITY signed words held in a row of cells, one word per cell,
// head in cell zero. One request is in flight at a time, and the next request is taken
// while the previous response still waits on the response channel. On an insert, the
// cells above the insert position shift up by one position together and the new word
// enters at that position. A remove or a get reads the word at the resolved position pos:
// the word at pos reaches the head through the row's read chain at one position per
// cycle, and a get first reduces the index modulo the entry count in the bit-serial
// remainder unit. Refused requests and unused action codes go straight to the response.
`include "positional_list_engine_top_macros.svh"

module positional_list_engine_top #(
   parameter int CAPACITY   = plc_pkg::DEF_CAPACITY,
   parameter int VALUE_BITS = plc_pkg::DEF_VALUE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [plc_pkg::ACTION_BITS-1:0]        req_action,
   input  logic [plc_pkg::INDEX_BITS-1:0]         req_index,
   input  logic signed [plc_pkg::RESULT_BITS-1:0] req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [plc_pkg::RESULT_BITS-1:0] rsp_result_value,
   output logic [plc_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [plc_pkg::COUNT_BITS-1:0]         rsp_entry_count
);
   import plc_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   // Control and working registers.
   state_type                state_ff;
   state_type                state_in;
   action_type               action_ff;
   action_type               action_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [POS_W-1:0]         pos_ff;
   logic [POS_W-1:0]         pos_in;
   logic [POS_W-1:0]         scan_ff;
   logic [POS_W-1:0]         scan_in;
   logic [RESULT_BITS-1:0]   res_ff;
   logic [RESULT_BITS-1:0]   res_in;
   status_type               status_ff;
   status_type               status_in;

   // Response output register.
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RESULT_BITS-1:0]   rsp_value_ff;
   logic [RESULT_BITS-1:0]   rsp_value_in;
   status_type               rsp_status_ff;
   status_type               rsp_status_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff;
   logic [COUNT_BITS-1:0]    rsp_count_in;

   cell_ctl_type             cell_ctl;
   logic                     div_start;
   logic                     div_done;
   logic [CNT_W-1:0]         div_rem;
   logic [POS_MAX_BITS-1:0]  ins_pos;
   logic [POS_W-1:0]         rem_pos;
   logic [CNT_W-1:0]         last_idx;
   logic [VALUE_BITS-1:0]    insert_word;
   logic signed [VALUE_BITS-1:0] head_rd;

   logic [VALUE_BITS-1:0]    entry_w    [CAPACITY];
   logic [VALUE_BITS-1:0]    rd_w       [CAPACITY];
   logic [VALUE_BITS-1:0]    left_w     [CAPACITY];
   logic [VALUE_BITS-1:0]    right_w    [CAPACITY];
   logic [VALUE_BITS-1:0]    right_rd_w [CAPACITY];

   // Word going into the list, sign-extended or cut to the stored width.
   assign insert_word = VALUE_BITS'(req_value);
   assign head_rd     = signed'(rd_w[0]);

   // Position of an insert (clamped to the tail) and of a remove (clamped to the last entry).
   assign last_idx = count_ff - 1'b1;
   assign ins_pos  = (req_index >= INDEX_BITS'(count_ff)) ? POS_MAX_BITS'(count_ff)
                                                          : POS_MAX_BITS'(req_index);
   assign rem_pos  = (req_index >= INDEX_BITS'(last_idx)) ? POS_W'(last_idx)
                                                          : POS_W'(req_index);

   // Row of cells; each cell sees its neighbors' words and the right neighbor's read word.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_w[i] = '0;
      end else begin : g_inner_left
         assign left_w[i] = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_w[i]    = '0;
         assign right_rd_w[i] = '0;
      end else begin : g_inner_right
         assign right_w[i]    = entry_w[i+1];
         assign right_rd_w[i] = rd_w[i+1];
      end
      plc_cell #(
         .VALUE_BITS(VALUE_BITS),
         .CELL_INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .insert_word(insert_word),
         .left_word  (left_w[i]),
         .right_word (right_w[i]),
         .right_rd   (right_rd_w[i]),
         .entry      (entry_w[i]),
         .rd         (rd_w[i])
      );
   end

   // Index modulo entry count for get requests.
   plc_mod #(
      .DIVISOR_BITS(CNT_W)
   ) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_index),
      .divisor  (count_ff),
      .done     (div_done),
      .remainder(div_rem)
   );

   // Sequencer: next state, cell operation and register updates.
   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      scan_in       = scan_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      cell_ctl.op   = CELL_HOLD;
      cell_ctl.pos  = POS_MAX_BITS'(pos_ff);
      div_start     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in = action_type'(req_action);
               res_in    = '0;
               status_in = STAT_DONE;
               state_in  = S_FINISH;
               unique case (action_type'(req_action))
                  ACT_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = STAT_FULL;
                     end else begin
                        cell_ctl.op  = CELL_INSERT;
                        cell_ctl.pos = ins_pos;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        pos_in   = rem_pos;
                        state_in = S_LOAD;
                     end
                  end
                  ACT_GET: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               pos_in   = POS_W'(div_rem);
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cell_ctl.op = CELL_LOAD;
            scan_in     = pos_ff;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (scan_ff == '0) begin
               res_in = RESULT_BITS'(head_rd);
               if (action_ff == ACT_REMOVE) begin
                  cell_ctl.op = CELL_REMOVE;
                  count_in    = count_ff - 1'b1;
               end
               state_in = S_FINISH;
            end else begin
               cell_ctl.op = CELL_SHIFT;
               scan_in     = scan_ff - 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_BITS'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      pos_ff        <= pos_in;
      scan_ff       <= scan_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = signed'(rsp_value_ff);
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

   // An accepted request always leaves the idle state.
   `PLC_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_ff != S_IDLE,
      "Accepted request did not start work.")
   // A finished request whose slot is free produces a response in the next cycle.
   `PLC_ASSERT_NEXT(a_finish_rsp, state_ff == S_FINISH && (!rsp_valid_ff || !rsp_stall),
      rsp_valid_ff && state_ff == S_IDLE, "Finished request produced no response.")
   // The entry count changes only on an insert or at the end of a remove scan.
   `PLC_ASSERT_NEXT(a_count_stable, state_ff != S_IDLE && state_ff != S_SCAN,
      $stable(count_ff), "Entry count changed outside insert or remove.")
   // The read chain never runs past the resolved position.
   `PLC_ASSERT_NOW(a_scan_bound, state_ff == S_SCAN, scan_ff <= pos_ff,
      "Read chain counter exceeds the resolved position.")

endmodule

@@ hw/rtl/plc_cell.sv @@
module plc_cell #(
   parameter int VALUE_BITS = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                  clock,
   input  plc_pkg::cell_ctl_type ctl,
   input  logic [VALUE_BITS-1:0] insert_word,
   input  logic [VALUE_BITS-1:0] left_word,
   input  logic [VALUE_BITS-1:0] right_word,
   input  logic [VALUE_BITS-1:0] right_rd,
   output logic [VALUE_BITS-1:0] entry,
   output logic [VALUE_BITS-1:0] rd
);
   import plc_pkg::*;

   localparam logic [POS_MAX_BITS-1:0] MY_POS = POS_MAX_BITS'(CELL_INDEX);

   logic [VALUE_BITS-1:0] entry_ff;
   logic [VALUE_BITS-1:0] entry_in;
   logic [VALUE_BITS-1:0] rd_ff;
   logic [VALUE_BITS-1:0] rd_in;

   // Pick the next stored word and the next read-chain word from the broadcast operation.
   always_comb begin
      entry_in = entry_ff;
      rd_in    = rd_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            if (MY_POS > ctl.pos) begin
               entry_in = left_word;
            end else if (MY_POS == ctl.pos) begin
               entry_in = insert_word;
            end
         end
         CELL_REMOVE: begin
            if (MY_POS >= ctl.pos) begin
               entry_in = right_word;
            end
         end
         CELL_LOAD: begin
            rd_in = entry_ff;
         end
         CELL_SHIFT: begin
            rd_in = right_rd;
         end
         default: begin
         end
      endcase
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rd_ff    <= rd_in;
   end

   assign entry = entry_ff;
   assign rd    = rd_ff;

endmodule

@@ hw/rtl/plc_mod.sv @@
module plc_mod #(
   parameter int DIVISOR_BITS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plc_pkg::INDEX_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]        divisor,
   output logic                           done,
   output logic [DIVISOR_BITS-1:0]        remainder
);
   import plc_pkg::*;

   logic                    busy_ff;
   logic                    busy_in;
   logic                    done_ff;
   logic                    done_in;
   logic [STEP_BITS-1:0]    step_ff;
   logic [STEP_BITS-1:0]    step_in;
   logic [INDEX_BITS-1:0]   dividend_ff;
   logic [INDEX_BITS-1:0]   dividend_in;
   logic [DIVISOR_BITS-1:0] divisor_ff;
   logic [DIVISOR_BITS-1:0] divisor_in;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] rem_in;
   logic [DIVISOR_BITS:0]   trial;

   // Restoring remainder: one dividend bit per cycle, most significant first.
   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      step_in     = step_ff;
      dividend_in = dividend_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      trial       = {rem_ff, dividend_ff[INDEX_BITS-1]};
      if (start) begin
         busy_in     = 1'b1;
         step_in     = STEP_BITS'(INDEX_BITS - 1);
         dividend_in = dividend;
         divisor_in  = divisor;
         rem_in      = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = DIVISOR_BITS'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = DIVISOR_BITS'(trial);
         end
         dividend_in = {dividend_ff[INDEX_BITS-2:0], 1'b0};
         step_in     = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      dividend_ff <= dividend_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
